@@ rtl/ethernet_frame_parser_unit_assert.svh @@
// Assertion macros for the frame parser RTL
`ifndef ETHERNET_FRAME_PARSER_UNIT_ASSERT_SVH
`define ETHERNET_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied
`define EFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("efp assertion failed");

// Next-cycle implication, disabled while reset is applied
`define EFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("efp assertion failed");

`endif

@@ rtl/efp_pkg.sv @@
`default_nettype none
package efp_pkg;

	// CRC-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// Frame layout
	localparam logic [15:0] TAG_TYPE       = 16'h8100;
	localparam logic [4:0]  HDR_PLAIN      = 5'd14;
	localparam logic [4:0]  HDR_TAGGED     = 5'd18;
	localparam logic [4:0]  FCS_BYTES      = 5'd4;
	localparam logic [15:0] SIZE_MAX_RESET = 16'd1500;
	localparam int unsigned MAX_FRAME_BYTES_DEF = 16384;

	// Result queue
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_SHORT    = 2'd1,
		STATUS_OVERRUN  = 2'd2,
		STATUS_MISMATCH = 2'd3
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic        has_vlan_tag;
		logic [15:0] vlan_tag;
		logic [15:0] type_or_size;
		logic [15:0] payload_length;
		logic [31:0] fcs_received;
		logic [31:0] fcs_computed;
		status_t     status;
		logic        last;
	} result_t;

	// Results written into the queue together
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	// Advance the CRC by one byte, LSB first
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ rtl/efp_parse.sv @@
`default_nettype none
module efp_parse #(
	parameter int unsigned MAX_FRAME_BYTES = efp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic [15:0]   cfg_wr_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    data_byte,
	input  wire logic          frame_end,
	input  wire logic          room,
	output efp_pkg::push_t     push
);
	import efp_pkg::*;

	localparam logic [15:0] CNT_MAX = 16'(MAX_FRAME_BYTES);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        end_s1;
	logic        adv;

	logic [15:0] sfm_q;
	logic [15:0] cnt_q, cnt_n;
	logic [31:0] crc_q, crc_n;
	logic [7:0]  tail_q [4];
	logic [47:0] dst_q, dst_n;
	logic [47:0] src_q, src_n;
	logic        tag_q, tag_n;
	logic [15:0] tagw_q, tagw_n;
	logic [15:0] type_q, type_n;
	logic [15:0] sent_q, sent_n;

	logic [15:0] pos;
	logic [15:0] hdr_len;
	logic [15:0] short_thr;
	logic [31:0] fcs_rx;
	logic [31:0] fcs_calc;
	logic        emit;
	result_t     pay_r;
	result_t     sum_r;

	// Input register: take an item when the register is empty or the held one can move on
	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			end_s1  <= frame_end;
		end
	end

	// Size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sfm_q <= SIZE_MAX_RESET;
		end else if (cfg_wr_en) begin
			sfm_q <= cfg_wr_data;
		end
	end

	// Parse the byte leaving the tail delay and build the summary
	always_comb begin
		cnt_n  = cnt_q;
		crc_n  = crc_q;
		dst_n  = dst_q;
		src_n  = src_q;
		tag_n  = tag_q;
		tagw_n = tagw_q;
		type_n = type_q;
		sent_n = sent_q;
		emit   = 1'b0;
		pos     = cnt_q - 16'd4;
		hdr_len = tag_q ? 16'(HDR_TAGGED) : 16'(HDR_PLAIN);
		if (cnt_q >= 16'd4) begin
			crc_n = crc_byte(crc_q, tail_q[3]);
			if (pos < 16'd6) begin
				dst_n = {dst_q[39:0], tail_q[3]};
			end else if (pos < 16'd12) begin
				src_n = {src_q[39:0], tail_q[3]};
			end else if (pos < 16'd14) begin
				type_n = {type_q[7:0], tail_q[3]};
				if (pos == 16'd13 && type_n == TAG_TYPE && !tag_q) begin
					tag_n = 1'b1;
				end
			end else if (pos < hdr_len) begin
				if (pos < 16'd16) begin
					tagw_n = {tagw_q[7:0], tail_q[3]};
				end else begin
					type_n = {type_q[7:0], tail_q[3]};
				end
			end else if (!(type_q <= sfm_q && sent_q >= type_q)) begin
				emit = 1'b1;
				if (sent_q != 16'hFFFF) begin
					sent_n = sent_q + 16'd1;
				end
			end
		end
		if (cnt_q < CNT_MAX) begin
			cnt_n = cnt_q + 16'd1;
		end

		fcs_rx    = {tail_q[2], tail_q[1], tail_q[0], data_s1};
		fcs_calc  = ~crc_n;
		short_thr = tag_n ? 16'(HDR_TAGGED + FCS_BYTES) : 16'(HDR_PLAIN + FCS_BYTES);

		pay_r              = '0;
		pay_r.kind         = KIND_PAYLOAD;
		pay_r.payload_byte = tail_q[3];

		sum_r                = '0;
		sum_r.kind           = KIND_SUMMARY;
		sum_r.dst_mac        = dst_n;
		sum_r.src_mac        = src_n;
		sum_r.has_vlan_tag   = tag_n;
		sum_r.vlan_tag       = tagw_n;
		sum_r.type_or_size   = type_n;
		sum_r.payload_length = sent_n;
		sum_r.fcs_received   = fcs_rx;
		sum_r.fcs_computed   = fcs_calc;
		sum_r.last           = 1'b1;
		if (cnt_n < short_thr) begin
			sum_r.status = STATUS_SHORT;
		end else if (type_n <= sfm_q && sent_n < type_n) begin
			sum_r.status = STATUS_OVERRUN;
		end else if (fcs_rx != fcs_calc) begin
			sum_r.status = STATUS_MISMATCH;
		end else begin
			sum_r.status = STATUS_OK;
		end

		// Pack results for the queue: payload first, summary after it
		push.r0 = emit ? pay_r : sum_r;
		push.r1 = sum_r;
		if (!adv) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, emit} + {1'b0, end_s1};
		end
	end

	// Frame state: advance per item, clear after each summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= CRC_INIT;
			tail_q[0] <= '0;
			tail_q[1] <= '0;
			tail_q[2] <= '0;
			tail_q[3] <= '0;
			dst_q     <= '0;
			src_q     <= '0;
			tag_q     <= 1'b0;
			tagw_q    <= '0;
			type_q    <= '0;
			sent_q    <= '0;
		end else if (adv) begin
			if (end_s1) begin
				cnt_q     <= '0;
				crc_q     <= CRC_INIT;
				tail_q[0] <= '0;
				tail_q[1] <= '0;
				tail_q[2] <= '0;
				tail_q[3] <= '0;
				dst_q     <= '0;
				src_q     <= '0;
				tag_q     <= 1'b0;
				tagw_q    <= '0;
				type_q    <= '0;
				sent_q    <= '0;
			end else begin
				cnt_q     <= cnt_n;
				crc_q     <= crc_n;
				tail_q[0] <= data_s1;
				tail_q[1] <= tail_q[0];
				tail_q[2] <= tail_q[1];
				tail_q[3] <= tail_q[2];
				dst_q     <= dst_n;
				src_q     <= src_n;
				tag_q     <= tag_n;
				tagw_q    <= tagw_n;
				type_q    <= type_n;
				sent_q    <= sent_n;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/efp_out_queue.sv @@
`default_nettype none
`include "ethernet_frame_parser_unit_assert.svh"
module efp_out_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire efp_pkg::push_t  push,
	output logic                 room,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output efp_pkg::result_t     head
);
	import efp_pkg::*;

	result_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	// Leave space for the two results one item may produce
	assign room      = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign head      = mem_q[rd_ptr_q];

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + QPTR_W'(1)] <= push.r1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	`EFP_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= QCNT_W'(QUEUE_DEPTH))
	`EFP_ASSERT_IMPL(a_pair_fits, clk, arst_n, push.count == 2'd2, count_q <= QCNT_W'(QUEUE_DEPTH - 2))
	`EFP_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && push.count == 2'd0, count_q == $past(count_q) - QCNT_W'(1))

endmodule
`default_nettype wire

@@ rtl/ethernet_frame_parser_unit.sv @@
// Channel   Handshake               Payload
// config    cfg_wr_en               cfg_wr_data (size field limit)
// input     in_valid / in_ready     data_byte, frame_end
// output    out_valid / out_ready   kind, payload_byte, header fields, FCS values, status, last
//
// One byte item is accepted per cycle while the queue has room; it is held in the input
// register, parsed by the CRC and field logic behind it, and lands in a four-entry result queue.
// Payload bytes appear four items late, behind the four-byte FCS delay line.
// An item may yield two results, so sustained rate drops below one per cycle only
// when the output side stalls and the queue holds more than two results.
// Reset clears all frame state, sets the size limit to 1500 and empties the queue.
`default_nettype none
module ethernet_frame_parser_unit #(
	parameter int unsigned MAX_FRAME_BYTES = efp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr_en,
	input  wire logic [15:0]   cfg_wr_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    data_byte,
	input  wire logic          frame_end,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               kind,
	output logic [7:0]         payload_byte,
	output logic [47:0]        dst_mac,
	output logic [47:0]        src_mac,
	output logic               has_vlan_tag,
	output logic [15:0]        vlan_tag,
	output logic [15:0]        type_or_size,
	output logic [15:0]        payload_length,
	output logic [31:0]        fcs_received,
	output logic [31:0]        fcs_computed,
	output logic [1:0]         status,
	output logic               last
);
	import efp_pkg::*;

	push_t   push;
	logic    room;
	result_t head;

	efp_parse #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_end  (frame_end),
		.room       (room),
		.push       (push)
	);

	efp_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	// Unpack the head of the queue onto the result ports
	assign kind           = head.kind;
	assign payload_byte   = head.payload_byte;
	assign dst_mac        = head.dst_mac;
	assign src_mac        = head.src_mac;
	assign has_vlan_tag   = head.has_vlan_tag;
	assign vlan_tag       = head.vlan_tag;
	assign type_or_size   = head.type_or_size;
	assign payload_length = head.payload_length;
	assign fcs_received   = head.fcs_received;
	assign fcs_computed   = head.fcs_computed;
	assign status         = head.status;
	assign last           = head.last;

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
	import efp_pkg::*;

	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 8;
	localparam int STALL_LIMIT     = 5000;
	localparam int ITEMS_PER_PHASE = 20;

	// Expected parser output, worked out one byte at a time
	class frame_scoreboard;
		result_t     parser_out_due[$];
		int          errors;
		logic [15:0] size_limit;
		logic [15:0] bytes_seen;
		logic [31:0] crc_acc;
		logic [7:0]  fcs_window[4];
		logic [47:0] dst_acc;
		logic [47:0] src_acc;
		logic        tag_seen;
		logic [15:0] tag_acc;
		logic [15:0] type_acc;
		logic [15:0] delivered;
		logic [4:0]  hdr_len;

		function new();
			errors = 0;
			size_limit = SIZE_MAX_RESET;
			restart_frame();
		endfunction

		static function logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
			logic [31:0] c;
			c = crc ^ {24'd0, b};
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
			end
			return c;
		endfunction

		function void restart_frame();
			bytes_seen = '0;
			crc_acc = CRC_INIT;
			foreach (fcs_window[i]) fcs_window[i] = '0;
			dst_acc = '0;
			src_acc = '0;
			tag_seen = 1'b0;
			tag_acc = '0;
			type_acc = '0;
			delivered = '0;
			hdr_len = HDR_PLAIN;
		endfunction

		// Fold one byte clear of the FCS window into the header fields and CRC
		function bit absorb_byte(logic [15:0] pos, logic [7:0] b);
			crc_acc = crc_next(crc_acc, b);
			if (pos < 16'd6) begin
				dst_acc = {dst_acc[39:0], b};
			end else if (pos < 16'd12) begin
				src_acc = {src_acc[39:0], b};
			end else if (pos < 16'd14) begin
				type_acc = {type_acc[7:0], b};
				if (pos == 16'd13 && type_acc == TAG_TYPE && !tag_seen) begin
					tag_seen = 1'b1;
					hdr_len = HDR_TAGGED;
				end
			end else if (pos < {11'd0, hdr_len}) begin
				if (pos < 16'd16) tag_acc = {tag_acc[7:0], b};
				else type_acc = {type_acc[7:0], b};
			end else begin
				// drop bytes past a size-capped payload
				if (type_acc <= size_limit && delivered >= type_acc) return 1'b0;
				if (delivered != 16'hFFFF) delivered++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_byte(logic [7:0] b, logic e);
			result_t r;
			logic [7:0] oldest;
			oldest = fcs_window[3];
			if (bytes_seen >= 16'd4) begin
				if (absorb_byte(bytes_seen - 16'd4, oldest)) begin
					r = '0;
					r.kind = KIND_PAYLOAD;
					r.payload_byte = oldest;
					parser_out_due.push_back(r);
				end
			end
			fcs_window[3] = fcs_window[2];
			fcs_window[2] = fcs_window[1];
			fcs_window[1] = fcs_window[0];
			fcs_window[0] = b;
			if (bytes_seen < MAX_FRAME_BYTES_DEF) bytes_seen++;
			if (e) begin
				r = '0;
				r.kind = KIND_SUMMARY;
				r.dst_mac = dst_acc;
				r.src_mac = src_acc;
				r.has_vlan_tag = tag_seen;
				r.vlan_tag = tag_acc;
				r.type_or_size = type_acc;
				r.payload_length = delivered;
				r.fcs_received = {fcs_window[3], fcs_window[2], fcs_window[1], fcs_window[0]};
				r.fcs_computed = ~crc_acc;
				if (int'(bytes_seen) < int'(hdr_len) + 4) r.status = STATUS_SHORT;
				else if (type_acc <= size_limit && delivered < type_acc) r.status = STATUS_OVERRUN;
				else if (r.fcs_received != r.fcs_computed) r.status = STATUS_MISMATCH;
				else r.status = STATUS_OK;
				r.last = 1'b1;
				parser_out_due.push_back(r);
				restart_frame();
			end
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (parser_out_due.size() == 0) begin
				$error("result with nothing expected: kind %0d, last %0d", got.kind, got.last);
				errors++;
				return;
			end
			want = parser_out_due.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("payload_byte", want.payload_byte, got.payload_byte);
			check_field("dst_mac", want.dst_mac, got.dst_mac);
			check_field("src_mac", want.src_mac, got.src_mac);
			check_field("has_vlan_tag", want.has_vlan_tag, got.has_vlan_tag);
			check_field("vlan_tag", want.vlan_tag, got.vlan_tag);
			check_field("type_or_size", want.type_or_size, got.type_or_size);
			check_field("payload_length", want.payload_length, got.payload_length);
			check_field("fcs_received", want.fcs_received, got.fcs_received);
			check_field("fcs_computed", want.fcs_computed, got.fcs_computed);
			check_field("status", want.status, got.status);
			check_field("last", want.last, got.last);
		endfunction

		function int pending();
			return parser_out_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        frame_end;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [47:0] dst_mac;
	logic [47:0] src_mac;
	logic        has_vlan_tag;
	logic [15:0] vlan_tag;
	logic [15:0] type_or_size;
	logic [15:0] payload_length;
	logic [31:0] fcs_received;
	logic [31:0] fcs_computed;
	logic [1:0]  status;
	logic        last;

	frame_scoreboard board;
	result_t         observed;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	bit              hold_request;
	int              items_sent;
	int unsigned     quiet_cycles;

	ethernet_frame_parser_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.payload_byte   (payload_byte),
		.dst_mac        (dst_mac),
		.src_mac        (src_mac),
		.has_vlan_tag   (has_vlan_tag),
		.vlan_tag       (vlan_tag),
		.type_or_size   (type_or_size),
		.payload_length (payload_length),
		.fcs_received   (fcs_received),
		.fcs_computed   (fcs_computed),
		.status         (status),
		.last           (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check every result item taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed.kind = kind;
			observed.payload_byte = payload_byte;
			observed.dst_mac = dst_mac;
			observed.src_mac = src_mac;
			observed.has_vlan_tag = has_vlan_tag;
			observed.vlan_tag = vlan_tag;
			observed.type_or_size = type_or_size;
			observed.payload_length = payload_length;
			observed.fcs_received = fcs_received;
			observed.fcs_computed = fcs_computed;
			observed.status = status_t'(status);
			observed.last = last;
			board.check_result(observed);
		end
	end

	// End the run if neither channel moves an item for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: random back-pressure, with a long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
			@(negedge clk);
		end
	end

	// Offer one byte item, holding it until accepted
	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		frame_end <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_byte(b, e);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_noise(input int len);
		for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
	endtask

	// Build a frame with optional tag and a good or corrupted FCS, cut trim bytes off the end, send it
	task automatic send_frame(input logic [47:0] dst, input logic [47:0] src, input bit tag_it,
			input logic [15:0] tag, input logic [15:0] tw, input int n_pay, input bit fcs_ok,
			input int trim);
		logic [7:0]  q[$];
		logic [31:0] crc;
		q = {};
		for (int i = 5; i >= 0; i--) q.push_back(dst[8*i +: 8]);
		for (int i = 5; i >= 0; i--) q.push_back(src[8*i +: 8]);
		if (tag_it) begin
			q.push_back(TAG_TYPE[15:8]);
			q.push_back(TAG_TYPE[7:0]);
			q.push_back(tag[15:8]);
			q.push_back(tag[7:0]);
		end
		q.push_back(tw[15:8]);
		q.push_back(tw[7:0]);
		repeat (n_pay) q.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (q[i]) crc = frame_scoreboard::crc_next(crc, q[i]);
		crc = ~crc;
		if (!fcs_ok) crc = crc ^ (32'd1 << $urandom_range(31));
		for (int i = 3; i >= 0; i--) q.push_back(crc[8*i +: 8]);
		repeat (trim) begin
			if (q.size() > 1) void'(q.pop_back());
		end
		foreach (q[i]) send_byte(q[i], i == q.size() - 1);
	endtask

	// Hold the sender until every expected result has come, then settle
	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (board.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_size_limit(input logic [15:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		board.size_limit = v;
		cfg_wr_en <= 1'b0;
	endtask

	// Mostly well-formed frames with random content; some noise and cut frames
	task automatic random_traffic(input int n_items);
		int          stop_at;
		int          pick;
		int          n_pay;
		logic [15:0] tw;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_noise($urandom_range(1, 30));
			end else begin
				n_pay = ($urandom_range(9) == 0) ? $urandom_range(61, 200) : $urandom_range(0, 60);
				case ($urandom_range(9))
					0, 1, 2: begin
						tw = 16'(n_pay);
					end
					3: begin
						tw = 16'(n_pay + $urandom_range(1, 8));
					end
					4: begin
						tw = (n_pay > 0) ? 16'($urandom_range(0, n_pay - 1)) : 16'd0;
					end
					5: begin
						tw = board.size_limit;
					end
					6: begin
						tw = board.size_limit + 16'd1;
					end
					7: begin
						tw = TAG_TYPE;
					end
					default: begin
						tw = 16'($urandom);
					end
				endcase
				send_frame({16'($urandom), $urandom}, {16'($urandom), $urandom},
					$urandom_range(3) == 0, 16'($urandom), tw, n_pay,
					$urandom_range(99) < 85, (pick < 14) ? $urandom_range(1, 10) : 0);
			end
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		data_byte = '0;
		frame_end = 1'b0;
		send_idle_pct = 13;
		recv_idle_pct = 66;
		hold_request = 1'b0;
		items_sent = 0;
		quiet_cycles = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under the reset size limit
		send_noise(1);
		send_frame(48'hFFFF_FFFF_FFFF, 48'h0, 1'b0, 16'h0, 16'd0, 0, 1'b1, 0);
		send_frame(48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, 16'h0, 16'd0, 0, 1'b1, 1);
		send_frame(48'h0123_4567_89AB, 48'hFEDC_BA98_7654, 1'b1, 16'hFFFF, 16'd0, 0, 1'b1, 1);
		// second tag type after a tag is an ordinary type word
		send_frame(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 16'h0000, TAG_TYPE, 8, 1'b1, 0);
		send_frame(48'h0, 48'h0, 1'b0, 16'h0, 16'd46, 46, 1'b1, 0);
		send_frame(48'h0A0B_0C0D_0E0F, 48'h1, 1'b0, 16'h0, 16'd20, 12, 1'b1, 0);
		// overrun outranks mismatch, short outranks both
		send_frame(48'h2, 48'h3, 1'b0, 16'h0, 16'd20, 12, 1'b0, 0);
		send_frame(48'h4, 48'h5, 1'b0, 16'h0, 16'd40, 0, 1'b0, 3);
		send_frame(48'h6, 48'h7, 1'b0, 16'h0, 16'd10, 30, 1'b1, 0);
		send_frame(48'h8, 48'h9, 1'b1, 16'h5A5A, 16'd1500, 5, 1'b1, 0);
		send_frame(48'hA, 48'hB, 1'b0, 16'h0, 16'd1501, 5, 1'b1, 0);
		send_frame(48'hC, 48'hD, 1'b0, 16'h0, 16'h0800, 40, 1'b0, 0);
		send_frame(48'hE, 48'hF, 1'b0, 16'h0, 16'hFFFF, 3, 1'b1, 0);
		drain_results();

		// Sender mostly busy, receiver mostly stalled
		send_idle_pct = 13;
		recv_idle_pct = 66;
		random_traffic(ITEMS_PER_PHASE);
		hold_request = 1'b1;
		random_traffic(ITEMS_PER_PHASE);
		set_size_limit(16'd0);
		random_traffic(ITEMS_PER_PHASE);

		// Sender mostly idle, receiver mostly ready
		send_idle_pct = 66;
		recv_idle_pct = 13;
		set_size_limit(16'hFFFF);
		random_traffic(ITEMS_PER_PHASE);
		set_size_limit(16'($urandom_range(46, 1600)));
		random_traffic(ITEMS_PER_PHASE);

		// No idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_size_limit(SIZE_MAX_RESET);
		random_traffic(ITEMS_PER_PHASE);
		hold_request = 1'b1;
		random_traffic(ITEMS_PER_PHASE / 2);
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (board.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/efp_pkg.sv
rtl/efp_parse.sv
rtl/efp_out_queue.sv
rtl/ethernet_frame_parser_unit.sv
sim/tb_top.sv
